// ===== sv/two_key_code_lock_assert.svh =====
// ----------------------------------------------------------------------------
// two_key_code_lock_assert.svh
// Assertion macros for the two-key code lock; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef TWO_KEY_CODE_LOCK_ASSERT_SVH
`define TWO_KEY_CODE_LOCK_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TKL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tkl: implication check failed");
// next-cycle implication
`define TKL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tkl: next-cycle check failed");
`else
`define TKL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TKL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/tkl_pkg.sv =====
// ----------------------------------------------------------------------------
// tkl_pkg
// Shared types, constants and helpers of the two-key code lock.
// ----------------------------------------------------------------------------
package tkl_pkg;

  localparam int CODE_DIGITS_DEF = 6;
  localparam int HIST_W          = 8;
  localparam int CFG_W           = 4;
  localparam int CNT_OUT_W       = 3;

  localparam logic [CFG_W-1:0] DEB_RESET = 4'd6;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_LOCKED   = 2'd1,
    EV_UNLOCKED = 2'd2,
    EV_WRONG    = 2'd3
  } tkl_event_t;

  // debounced press strobes, one per key
  typedef struct packed {
    logic p0;
    logic p1;
  } tkl_press_t;

  // one result item
  typedef struct packed {
    logic                 locked;
    logic                 taken;
    logic [CNT_OUT_W-1:0] cnt;
    tkl_event_t           ev;
  } tkl_res_t;

  // debounce window mask; 0 acts as 1, above 8 acts as 8
  function automatic logic [HIST_W-1:0] win_mask(input logic [CFG_W-1:0] n);
    logic [CFG_W-1:0] c;
    logic [HIST_W:0]  m;
    c = n;
    if (n == '0) c = 4'd1;
    if (n > 4'(HIST_W)) c = 4'(HIST_W);
    m = (9'h1 << c) - 9'h1;
    return m[HIST_W-1:0];
  endfunction

endpackage

// ===== sv/tkl_ifs.sv =====
// ----------------------------------------------------------------------------
// tkl_ifs
// Valid/ready channels: key samples in, lock results out.
// ----------------------------------------------------------------------------
interface tkl_in_if;
  logic valid;
  logic ready;
  logic key0_pressed;
  logic key1_pressed;

  modport source (output valid, output key0_pressed, output key1_pressed, input ready);
  modport sink   (input valid, input key0_pressed, input key1_pressed, output ready);
endinterface

interface tkl_out_if;
  logic       valid;
  logic       ready;
  logic       is_locked;
  logic       digit_taken;
  logic [2:0] digits_entered;
  logic [1:0] event_res;

  modport source (output valid, output is_locked, output digit_taken,
                  output digits_entered, output event_res, input ready);
  modport sink   (input valid, input is_locked, input digit_taken,
                  input digits_entered, input event_res, output ready);
endinterface

// ===== sv/tkl_debounce.sv =====
// ----------------------------------------------------------------------------
// tkl_debounce
// Per-key shift history and debounced down flag; strobes a new press.
// ----------------------------------------------------------------------------
module tkl_debounce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      level,
  input  logic [tkl_pkg::HIST_W-1:0] mask,
  output logic                      pressed
);
  import tkl_pkg::*;

  logic [HIST_W-1:0] hist_r, hist_nxt;
  logic              down_r, down_nxt;
  logic              all_on, all_off;

  // shift in the sample, check the window
  always_comb begin
    hist_nxt = {hist_r[HIST_W-2:0], level};
    all_on   = (hist_nxt & mask) == mask;
    all_off  = (hist_nxt & mask) == '0;
    down_nxt = down_r;
    pressed  = 1'b0;
    if (!down_r && all_on) begin
      down_nxt = 1'b1;
      pressed  = en;
    end else if (down_r && all_off) begin
      down_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      down_r <= 1'b0;
    end else if (en) begin
      hist_r <= hist_nxt;
      down_r <= down_nxt;
    end
  end

endmodule

// ===== sv/tkl_core.sv =====
// ----------------------------------------------------------------------------
// tkl_core
// Digit entry and lock state: collects digits, sets or checks the code.
// ----------------------------------------------------------------------------
module tkl_core #(
  parameter int CODE_DIGITS = tkl_pkg::CODE_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  tkl_pkg::tkl_press_t press,
  output tkl_pkg::tkl_res_t   res
);
  import tkl_pkg::*;

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);

  typedef struct packed {
    logic [CODE_DIGITS-1:0] bits;
    logic [CNT_W-1:0]       cnt;
    logic                   locked;
    logic [CODE_DIGITS-1:0] code;
  } lk_state_t;

  lk_state_t  st_r, st_a, st_b;
  tkl_event_t ev_a, ev_b, ev_sel;

  // one digit into the entry, with completion handling
  function automatic lk_state_t enter_digit(input lk_state_t s, input logic d,
                                            output tkl_event_t ev);
    lk_state_t n;
    n    = s;
    ev   = EV_NONE;
    n.bits = (s.bits << 1) | CODE_DIGITS'(d);
    n.cnt  = s.cnt + 1'b1;
    if (n.cnt >= CNT_W'(CODE_DIGITS)) begin
      if (!s.locked) begin
        n.code   = n.bits;
        n.locked = 1'b1;
        ev       = EV_LOCKED;
      end else if (n.bits == s.code) begin
        n.locked = 1'b0;
        n.code   = '0;
        ev       = EV_UNLOCKED;
      end else begin
        ev = EV_WRONG;
      end
      n.bits = '0;
      n.cnt  = '0;
    end
    return n;
  endfunction

  // key0 digit first, then key1
  always_comb begin
    st_a = st_r;
    ev_a = EV_NONE;
    if (press.p0) st_a = enter_digit(st_r, 1'b0, ev_a);
    st_b = st_a;
    ev_b = EV_NONE;
    if (press.p1) st_b = enter_digit(st_a, 1'b1, ev_b);
    ev_sel = (ev_b != EV_NONE) ? ev_b : ev_a;
  end

  // result fields: locked, taken, count, event
  assign res = {st_b.locked, press.p0 | press.p1, CNT_OUT_W'(st_b.cnt), ev_sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (en) begin
      st_r <= st_b;
    end
  end

endmodule

// ===== sv/two_key_code_lock.sv =====
// ----------------------------------------------------------------------------
// two_key_code_lock
// Two-key combination lock with per-key debounce, one sample per transfer.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | key0_pressed, key1_pressed
//  out_ch   | out | valid/ready  | is_locked, digit_taken, digits_entered,
//           |     |              | event_res
//  cfg      | in  | cfg_we       | cfg_wdata = debounce_samples
//
// One sample per cycle sustained unless the result stalls. A transfer passes
// the input register, then debounce and lock update into the result register.
// Synchronous active-low reset clears all key, entry and lock state and sets
// the debounce window to six samples. A stalled result holds both stages; the
// input register still takes a transfer while it is empty.
// ----------------------------------------------------------------------------
`include "two_key_code_lock_assert.svh"

module two_key_code_lock #(
  parameter int CODE_DIGITS = tkl_pkg::CODE_DIGITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  tkl_in_if.sink                   in_ch,
  tkl_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [tkl_pkg::CFG_W-1:0] cfg_wdata
);
  import tkl_pkg::*;

  logic              in_vld_r, k0_r, k1_r;
  logic              out_vld_r;
  tkl_res_t          res_r, res_c;
  logic [HIST_W-1:0] mask_r;
  logic              adv, fire;
  logic              deb_p0, deb_p1;
  tkl_press_t        press;

  // pipeline control
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = !in_vld_r || adv;
  assign fire         = in_vld_r && adv;

  // debounce window, decoded on write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= win_mask(DEB_RESET);
    end else if (cfg_we) begin
      mask_r <= win_mask(cfg_wdata);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      k0_r <= in_ch.key0_pressed;
      k1_r <= in_ch.key1_pressed;
    end
  end

  tkl_debounce u_deb0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (fire),
    .level   (k0_r),
    .mask    (mask_r),
    .pressed (deb_p0)
  );

  tkl_debounce u_deb1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (fire),
    .level   (k1_r),
    .mask    (mask_r),
    .pressed (deb_p1)
  );

  // press strobes, key0 then key1
  assign press = {deb_p0, deb_p1};

  tkl_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (fire),
    .press (press),
    .res   (res_c)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_c;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.is_locked      = res_r.locked;
  assign out_ch.digit_taken    = res_r.taken;
  assign out_ch.digits_entered = res_r.cnt;
  assign out_ch.event_res      = res_r.ev;

  // an event only comes with a digit
  `TKL_ASSERT_IMP(a_ev_needs_digit, clk, rst_n,
                  out_vld_r && res_r.ev != EV_NONE, res_r.taken)
  // lock flag agrees with the reported event
  `TKL_ASSERT_IMP(a_ev_lock_state, clk, rst_n,
                  out_vld_r && (res_r.ev == EV_LOCKED || res_r.ev == EV_WRONG),
                  res_r.locked)
  // a stalled input stage keeps its item
  `TKL_ASSERT_NXT(a_in_hold, clk, rst_n, in_vld_r && !adv, in_vld_r)

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-key code lock. A short stimulus table
// walks reset, code set, unlock and the debounce extremes; random phases
// then mix code entries, single presses and key noise under several
// debounce settings and handshake pressure. Every result transfer is
// checked against a table result or an in-bench model of the lock.
// ----------------------------------------------------------------------------
module testbench;
  import tkl_pkg::*;

  localparam int DIGITS = CODE_DIGITS_DEF;

  typedef enum logic {ROW_KEYS, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic             k0;
    logic             k1;
    logic [CFG_W-1:0] cfg;
    bit               typed;
    tkl_res_t         res;
  } stim_row_t;

  localparam tkl_res_t NO_RES = '{1'b0, 1'b0, 3'd0, EV_NONE};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  tkl_in_if  in_ch();
  tkl_out_if out_ch();

  two_key_code_lock dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // lock model state
  logic [CFG_W-1:0]  deb_setting;
  logic [HIST_W-1:0] hist0, hist1;
  logic              down0, down1;
  logic [DIGITS-1:0] entry_bits;
  int                entry_cnt;
  logic              lock_state;
  logic [DIGITS-1:0] saved_code;

  tkl_res_t pending_results[$];
  int       mismatch_count = 0;
  int       items_sent = 0;
  int       src_idle_pct = 0;
  int       sink_stall_pct = 0;

  // directed table: reset, code set, unlock, debounce extremes
  stim_row_t dir_rows [27] = '{
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b1, '{1'b0, 1'b0, 3'd0, EV_NONE}},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b1, '{1'b0, 1'b0, 3'd0, EV_NONE}},
    '{ROW_CFG,  1'b0, 1'b0, 4'd1,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b1, '{1'b1, 1'b1, 3'd0, EV_LOCKED}},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b1, '{1'b0, 1'b1, 3'd0, EV_UNLOCKED}},
    '{ROW_CFG,  1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b1, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES},
    // key0 completes the entry, key1 opens the next one
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b1, '{1'b1, 1'b1, 3'd1, EV_LOCKED}},
    '{ROW_CFG,  1'b0, 1'b0, 4'd15, 1'b0, NO_RES},
    '{ROW_KEYS, 1'b1, 1'b1, 4'd0,  1'b0, NO_RES},
    '{ROW_KEYS, 1'b0, 1'b0, 4'd0,  1'b0, NO_RES}
  };

  // debounce settings per random phase
  int deb_plan [9] = '{1, 2, 0, 3, 8, 1, 15, 4, 7};

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Lock model
  // ---------------------------------------------------------------------------

  // window of samples that must agree; 0 acts as 1, above 8 acts as 8
  function automatic logic [HIST_W-1:0] window_mask();
    logic [CFG_W-1:0] n;
    n = deb_setting;
    if (n == 4'd0) n = 4'd1;
    else if (n > 4'd8) n = 4'd8;
    return 8'((16'd1 << n) - 16'd1);
  endfunction

  // shift in one sample, return 1 on a newly accepted press
  function automatic logic filter_key(inout logic [HIST_W-1:0] hist, inout logic down,
                                      input logic level);
    logic [HIST_W-1:0] win;
    logic              hit;
    win = window_mask();
    hit = 1'b0;
    hist = {hist[HIST_W-2:0], level};
    if (!down && (hist & win) == win) begin
      down = 1'b1;
      hit = 1'b1;
    end else if (down && (hist & win) == '0) begin
      down = 1'b0;
    end
    return hit;
  endfunction

  function automatic tkl_event_t add_digit(input logic d);
    tkl_event_t ev;
    ev = EV_NONE;
    entry_bits = {entry_bits[DIGITS-2:0], d};
    entry_cnt++;
    if (entry_cnt >= DIGITS) begin
      if (!lock_state) begin
        saved_code = entry_bits;
        lock_state = 1'b1;
        ev = EV_LOCKED;
      end else if (entry_bits == saved_code) begin
        lock_state = 1'b0;
        saved_code = '0;
        ev = EV_UNLOCKED;
      end else begin
        ev = EV_WRONG;
      end
      entry_bits = '0;
      entry_cnt = 0;
    end
    return ev;
  endfunction

  // one key sample in, the lock result it produces out
  function automatic tkl_res_t next_lock_result(input logic k0, input logic k1);
    tkl_res_t   r;
    tkl_event_t ev, e;
    logic       taken;
    taken = 1'b0;
    ev = EV_NONE;
    if (filter_key(hist0, down0, k0)) begin
      taken = 1'b1;
      e = add_digit(1'b0);
      if (e != EV_NONE) ev = e;
    end
    if (filter_key(hist1, down1, k1)) begin
      taken = 1'b1;
      e = add_digit(1'b1);
      if (e != EV_NONE) ev = e;
    end
    r.locked = lock_state;
    r.taken = taken;
    r.cnt = 3'(entry_cnt);
    r.ev = ev;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // one sample transfer; entered and left at a falling edge
  task automatic put_sample(input logic k0, input logic k1, input bit typed,
                            input tkl_res_t typed_res);
    tkl_res_t model_res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.key0_pressed = k0;
    in_ch.key1_pressed = k1;
    do @(posedge clk); while (!in_ch.ready);
    model_res = next_lock_result(k0, k1);
    pending_results.push_back(typed ? typed_res : model_res);
    items_sent++;
    @(negedge clk);
  endtask

  // stop sending and let every outstanding result arrive
  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_debounce(input logic [CFG_W-1:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    deb_setting = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // a press long enough to pass the current window, sometimes a bit longer
  function automatic int hold_len();
    return $countones(window_mask()) + $urandom_range(0, 2);
  endfunction

  task automatic press_keys(input logic [1:0] kp, input int hold, input int rel);
    repeat (hold) put_sample(kp[0], kp[1], 1'b0, NO_RES);
    repeat (rel) put_sample(1'b0, 1'b0, 1'b0, NO_RES);
  endtask

  // one clean digit, occasionally preceded by a bounce too short to count
  task automatic press_digit(input logic d);
    logic [1:0] kp;
    int         win;
    kp = d ? 2'b10 : 2'b01;
    win = $countones(window_mask());
    if (win > 1 && $urandom_range(9) == 0) press_keys(kp, $urandom_range(1, win - 1), 1);
    press_keys(kp, hold_len(), hold_len());
  endtask

  // full code entry; when locked, half the time it is the stored code
  task automatic enter_code();
    logic [DIGITS-1:0] target;
    press_keys(2'b00, 0, hold_len());
    while (entry_cnt != 0) press_digit(1'($urandom_range(1)));
    target = (lock_state && $urandom_range(1)) ? saved_code : DIGITS'($urandom);
    for (int i = DIGITS - 1; i >= 0; i--) press_digit(target[i]);
  endtask

  initial begin
    int base;
    int pick;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.key0_pressed = 1'b0;
    in_ch.key1_pressed = 1'b0;
    out_ch.ready = 1'b1;
    deb_setting = DEB_RESET;
    hist0 = '0;
    hist1 = '0;
    down0 = 1'b0;
    down1 = 1'b0;
    entry_bits = '0;
    entry_cnt = 0;
    lock_state = 1'b0;
    saved_code = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_debounce(dir_rows[i].cfg);
      end else begin
        put_sample(dir_rows[i].k0, dir_rows[i].k1, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // random phases; each starts from an idle block with a new window
    for (int p = 0; p < 9; p++) begin
      drain_results();
      write_debounce(CFG_W'(deb_plan[p]));
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 72; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 72; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      base = items_sent;
      while (items_sent - base < 195) begin
        pick = $urandom_range(99);
        if (pick < 60) enter_code();
        else if (pick < 85) press_keys(2'($urandom_range(1, 3)), hold_len(), hold_len());
        else repeat ($urandom_range(1, 8))
          put_sample(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, NO_RES);
      end
    end

    // wind down and report
    drain_results();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Result check, oldest expectation first
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    tkl_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result: locked=%0d taken=%0d digits=%0d event=%0d",
                 $time, out_ch.is_locked, out_ch.digit_taken, out_ch.digits_entered,
                 out_ch.event_res);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.is_locked !== want.locked || out_ch.digit_taken !== want.taken ||
            out_ch.digits_entered !== want.cnt || out_ch.event_res !== want.ev) begin
          mismatch_count++;
          $display("%0t: mismatch: expected locked=%0d taken=%0d digits=%0d event=%0d, %s",
                   $time, want.locked, want.taken, want.cnt, want.ev, "actual below");
          $display("%0t:           actual locked=%0d taken=%0d digits=%0d event=%0d",
                   $time, out_ch.is_locked, out_ch.digit_taken, out_ch.digits_entered,
                   out_ch.event_res);
        end
      end
    end
  end

  // watchdog
  initial begin
    #4_800_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
